// ===== rtl/gcrms_pkg.sv =====
package gcrms_pkg;

  // Field widths
  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int SAMPLES_W = 11;
  localparam int RMS_W     = 16;
  localparam int TIME_W    = 48;
  localparam int SUM_W     = 41;
  localparam int SQ_W      = 2 * SAMPLE_W;
  localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;
  localparam int FRAC_BITS = 13;

  // Gain register
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd8192;
  localparam logic [GAIN_W-1:0] GAIN_LIMIT = 16'd32768;

  // Frame length default
  localparam int FRAME_MAX_DEF = 1024;

  // Square root unit: two radicand bits per step
  localparam int RAD_W      = SUM_W + 1;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int SREM_W     = ROOT_W + 1;
  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int STEP_W     = 6;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       frame_end;
    logic [SAMPLES_W-1:0]       frame_samples;
    logic [RMS_W-1:0]           frame_rms;
    logic [TIME_W-1:0]          frame_start_time;
  } out_item_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic sqr;
    logic acc;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic out_load;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic closes;
  } dp_status_t;

endpackage

// ===== rtl/gcrms_datapath.sv =====
module gcrms_datapath
  import gcrms_pkg::*;
#(
  parameter int FRAME_MAX = FRAME_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [GAIN_W-1:0]    cfg_wdata,
  input  in_item_t             in_data,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  output out_item_t            out_data
);

  localparam int CNT_W = $clog2(FRAME_MAX + 1);
  localparam int LEN_X = (CNT_W > SAMPLES_W) ? CNT_W : SAMPLES_W;

  // Control state
  logic [GAIN_W-1:0]          gain_r;
  logic [SUM_W-1:0]           sum_r, sum_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [TIME_W-1:0]          clock_r;

  // Payload registers
  logic signed [SAMPLE_W-1:0] smp_r;
  logic                       bend_r;
  logic [GAIN_W-1:0]          g_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [SAMPLE_W-1:0] y_r;
  logic [SQ_W-1:0]            sq_r;
  logic                       close_r;
  logic [CNT_W-1:0]           len_r;
  logic [TIME_W-1:0]          start_r;
  logic [SUM_W-1:0]           dq_r;
  logic [CNT_W-1:0]           drem_r;
  logic [RAD_W-1:0]           sv_r;
  logic [SREM_W-1:0]          srem_r;
  logic [ROOT_W-1:0]          root_r;
  out_item_t                  out_r;

  // Combinational helpers
  logic signed [PROD_W-FRAC_BITS-1:0] shifted;
  logic signed [SAMPLE_W-1:0]         y_sat;
  logic signed [SQ_W-1:0]             y_sq;
  logic                               closes;
  logic [TIME_W-1:0]                  start_now;
  logic [CNT_W:0]                     drem_sh, ddiff;
  logic                               dge;
  logic [SREM_W+1:0]                  srem_sh, strial, sdiff;
  logic                               sge;
  logic [LEN_X-1:0]                   len_x;

  // Floor shift and saturate to the sample range
  always_comb begin
    shifted = prod_r[PROD_W-1:FRAC_BITS];
    if (shifted > $signed((PROD_W-FRAC_BITS)'(32767))) begin
      y_sat = 16'sh7FFF;
    end else if (shifted < $signed(-(PROD_W-FRAC_BITS)'(32768))) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat = shifted[SAMPLE_W-1:0];
    end
    y_sq = y_sat * y_sat;
  end

  // Frame accounting
  always_comb begin
    sum_nxt   = sum_r + SUM_W'(sq_r);
    cnt_nxt   = cnt_r + CNT_W'(1);
    closes    = bend_r || (cnt_nxt >= CNT_W'(FRAME_MAX));
    start_now = clock_r - TIME_W'(cnt_r);
  end

  // One restoring division step
  always_comb begin
    drem_sh = {drem_r, dq_r[SUM_W-1]};
    ddiff   = drem_sh - {1'b0, len_r};
    dge     = drem_sh >= {1'b0, len_r};
  end

  // One square root step
  always_comb begin
    srem_sh = {srem_r, sv_r[RAD_W-1 -: 2]};
    strial  = {1'b0, root_r, 2'b01};
    sdiff   = srem_sh - strial;
    sge     = srem_sh >= strial;
  end

  assign len_x = LEN_X'(len_r);

  // Gain register and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= GAIN_RESET;
      sum_r   <= '0;
      cnt_r   <= '0;
      clock_r <= '0;
    end else begin
      if (cfg_we) begin
        gain_r <= cfg_wdata;
      end
      if (cmd.acc) begin
        clock_r <= clock_r + TIME_W'(1);
        if (closes) begin
          sum_r <= '0;
          cnt_r <= '0;
        end else begin
          sum_r <= sum_nxt;
          cnt_r <= cnt_nxt;
        end
      end
    end
  end

  // Item pipeline, divider and root unit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp_r  <= in_data.sample;
      bend_r <= in_data.buffer_end;
      g_r    <= (gain_r > GAIN_LIMIT) ? GAIN_LIMIT : gain_r;
    end
    if (cmd.mul) begin
      prod_r <= smp_r * $signed({1'b0, g_r});
    end
    if (cmd.sqr) begin
      y_r  <= y_sat;
      sq_r <= y_sq[SQ_W-1:0];
    end
    if (cmd.acc) begin
      close_r <= closes;
      len_r   <= cnt_nxt;
      start_r <= start_now;
      dq_r    <= sum_nxt;
      drem_r  <= '0;
    end
    if (cmd.div_step) begin
      drem_r <= dge ? ddiff[CNT_W-1:0] : drem_sh[CNT_W-1:0];
      dq_r   <= {dq_r[SUM_W-2:0], dge};
    end
    if (cmd.sqrt_init) begin
      sv_r   <= RAD_W'(dq_r);
      srem_r <= '0;
      root_r <= '0;
    end
    if (cmd.sqrt_step) begin
      srem_r <= sge ? sdiff[SREM_W-1:0] : srem_sh[SREM_W-1:0];
      root_r <= {root_r[ROOT_W-2:0], sge};
      sv_r   <= {sv_r[RAD_W-3:0], 2'b00};
    end
    if (cmd.out_load) begin
      out_r.out_sample <= y_r;
      out_r.frame_end  <= close_r;
      if (close_r) begin
        out_r.frame_samples    <= len_x[SAMPLES_W-1:0];
        out_r.frame_rms        <= root_r[RMS_W-1:0];
        out_r.frame_start_time <= start_r;
      end else begin
        out_r.frame_samples    <= '0;
        out_r.frame_rms        <= '0;
        out_r.frame_start_time <= '0;
      end
    end
  end

  assign status.closes = closes;
  assign out_data      = out_r;

endmodule

// ===== rtl/gcrms_ctrl.sv =====
module gcrms_ctrl
  import gcrms_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_SQR  = 8'b0000_0100,
    S_ACC  = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_SQI  = 8'b0010_0000,
    S_SQRT = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Sequence one item through the datapath
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SQR;
      end
      S_SQR: begin
        cmd.sqr   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        step_nxt  = '0;
        state_nxt = status.closes ? S_DIV : S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_SQI;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_SQI: begin
        cmd.sqrt_init = 1'b1;
        step_nxt      = '0;
        state_nxt     = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (step_r == STEP_W'(SQRT_STEPS - 1)) begin
          state_nxt = S_DONE;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/gain_clip_frame_rms_meter.sv =====
// Gain, clip and frame RMS level meter for a mono Q1.15 capture stream.
// Input channel (in_valid/in_ready/in_data): one sample and a buffer-end
// flag per item. Output channel (out_valid/out_ready/out_data): one result
// per item, the gain-scaled saturated sample and, on the item that closes
// a frame, its length, start time in samples and floor RMS.
// Configuration: cfg_we writes cfg_wdata to the Q3.13 gain, values above
// 4.0 act as 4.0. Write it only while the block is idle.
// Sequence: each item is loaded, scaled, squared and accumulated, and its
// result moves to the output register; an item that closes a frame first
// runs the 41-step restoring divider (one quotient bit a cycle) and the
// 21-step square root unit (two radicand bits a cycle), one after the
// other. The next item is accepted once the current result sits in the
// output register.
// Reset (rst_n low, synchronous) restores unity gain, empties the open
// frame and clears the sample clock. A stalled receiver holds the result in
// the output register; a further item is still taken and processed, and
// waits in the last step until that register is free.
module gain_clip_frame_rms_meter
  import gcrms_pkg::*;
#(
  parameter int FRAME_MAX = FRAME_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [GAIN_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  gcrms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  gcrms_datapath #(
    .FRAME_MAX (FRAME_MAX)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
